// File: rtl/bth_pkg.sv
// shared types and codes for the boundary tag heap allocator
// no dependencies; imported by every rtl module of the block except bth_ram
`default_nettype none

package bth_pkg;

    localparam int HEAP_WORDS_DEF = 64;

    localparam logic [1:0] KIND_FIRST = 2'd0;
    localparam logic [1:0] KIND_BEST  = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;

    localparam logic [1:0] ST_ALLOC   = 2'd0;
    localparam logic [1:0] ST_FREED   = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_BADADDR = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] size_class;
        logic [6:0] block_address;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] start_address;
    } rsp_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_INIT_WR,
        DP_RD_H,
        DP_FIT_CHK,
        DP_FIT_RST,
        DP_CO_START,
        DP_CO_TST,
        DP_WR_HDR,
        DP_WR_FTR,
        DP_PLACE1,
        DP_PLACE2,
        DP_FR_ADV,
        DP_FR_HDR,
        DP_RD_PREV,
        DP_RD_P2,
        DP_RD_END,
        DP_PAD_B,
        DP_PAD_A,
        DP_REL_P,
        DP_REL_N,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] res;
    } ctl_cmd_t;

    typedef struct packed {
        logic init_last;
        logic kind_alloc;
        logic kind_free;
        logic addr_bad;
        logic h_end;
        logic pick_ok;
        logic fit_stop;
        logic co_good;
        logic co_reach;
        logic split;
        logic fr_cont;
        logic fr_match;
        logic hdr_is_pad;
        logic hdr_alloc;
        logic h_pos;
        logic p2_in;
        logic pad_go;
        logic rel_p_ok;
        logic end_in;
        logic rel_n_ok;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/boundary_tag_heap_allocator_core.sv
// top level of the boundary tag heap allocator: controller plus datapath
// depends on bth_pkg, bth_ctrl, bth_datapath, bth_ram
//
//   channel | signals                  | payload
//   --------+--------------------------+-----------------------------------
//   request | req_valid / req_ready    | req  (kind, size_class, block_address)
//   result  | rsp_valid / rsp_ready    | rsp  (status, start_address)
//
// one item at a time; single read port tag store, so each block visited takes a read state
// and a check state; alloc: accept, dispatch, search, then place (header and footer write)
// and a second header and footer write on a split; best fit walks the whole heap; a failed
// search adds a coalescing walk and a rewrite of the merged run before searching again
// free: walk the blocks up to the address, read the header, release and merge, check padding
// after reset a clearing pass writes the initial tags to every word; no item
// is taken meanwhile; a result waits in the output register, a new one stalls until it goes
`default_nettype none

module boundary_tag_heap_allocator_core
    import bth_pkg::*;
#(
    parameter int HEAP_WORDS = HEAP_WORDS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    ctl_cmd_t cmd;
    dp_stat_t st;

    bth_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .st       (st),
        .cmd      (cmd)
    );

    bth_datapath #(
        .HEAP_WORDS(HEAP_WORDS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

// File: rtl/bth_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module bth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/bth_datapath.sv
// datapath: tag store, walk pointers, block write setup and result register
// depends on bth_pkg and bth_ram
`default_nettype none

module bth_datapath
    import bth_pkg::*;
#(
    parameter int HEAP_WORDS = HEAP_WORDS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ctl_cmd_t cmd,
    output dp_stat_t      st,
    input  wire req_t     req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output rsp_t          rsp
);

    localparam int AW    = $clog2(HEAP_WORDS);
    localparam int SW    = $clog2(HEAP_WORDS + 1);
    localparam int XW    = ((SW + 1) > 7) ? SW + 1 : 7;
    localparam int LAST  = ((HEAP_WORDS - 4) / 4) * 4;
    localparam int LSIZE = HEAP_WORDS - LAST;

    localparam logic [XW-1:0] N_X     = XW'(HEAP_WORDS);
    localparam logic [XW-1:0] LAST_X  = XW'(LAST);
    localparam logic [XW-1:0] LSIZE_X = XW'(LSIZE);
    localparam logic [XW-1:0] ONE_X   = XW'(1);
    localparam logic [XW-1:0] TWO_X   = XW'(2);
    localparam logic [XW-1:0] FOUR_X  = XW'(4);

    req_t          req_reg;
    logic [XW-1:0] h_reg, start_reg, end_reg, acc_reg, pick_reg, plen_reg;
    logic [XW-1:0] wb_h_reg, wb_s_reg;
    logic          wb_a_reg, pick_ok_reg, before_reg, after_reg, out_valid_reg;
    rsp_t          rsp_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [SW:0]   wdata, rdata;

    logic          r_alloc;
    logic [XW-1:0] r_size, s1, room, len, need, acc_new, a_x, ftr_x, init_size;
    logic [XW-1:0] remain, ps_start;
    logic          wb_ok, fit_good, best_better, co_good;

    bth_ram #(
        .WIDTH(SW + 1),
        .DEPTH(HEAP_WORDS)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        r_alloc  = rdata[SW];
        r_size   = XW'(rdata[SW-1:0]);
        s1       = (r_size == '0) ? ONE_X : r_size;
        room     = N_X - h_reg;
        len      = (s1 > room) ? room : s1;
        need     = (TWO_X << req_reg.size_class) + TWO_X;
        acc_new  = acc_reg + len;
        a_x      = XW'(req_reg.block_address) - ONE_X;
        ftr_x    = wb_h_reg + wb_s_reg - ONE_X;
        remain   = plen_reg - need;
        ps_start = h_reg - r_size;
        wb_ok    = (wb_s_reg >= ONE_X) && (wb_h_reg < N_X) && (wb_s_reg <= N_X - wb_h_reg);
        fit_good = !r_alloc && (len >= need);
        best_better = !pick_ok_reg || (len < plen_reg);
        co_good  = !r_alloc || (r_size == TWO_X);
        // reset layout: four-word blocks, the last one takes what is left
        if (h_reg < LAST_X)
        begin
            init_size = (h_reg[1:0] == 2'd0 || h_reg[1:0] == 2'd3) ? FOUR_X : ONE_X;
        end
        else
        begin
            init_size = (h_reg == LAST_X || h_reg == N_X - ONE_X) ? LSIZE_X : ONE_X;
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = h_reg[AW-1:0];
        wdata = {1'b0, init_size[SW-1:0]};
        raddr = h_reg[AW-1:0];
        unique case (cmd.op)
            DP_INIT_WR: we = 1'b1;
            DP_WR_HDR:
            begin
                we    = wb_ok;
                waddr = wb_h_reg[AW-1:0];
                wdata = {wb_a_reg, wb_s_reg[SW-1:0]};
            end
            DP_WR_FTR:
            begin
                we    = wb_ok;
                waddr = ftr_x[AW-1:0];
                wdata = {wb_a_reg, wb_s_reg[SW-1:0]};
            end
            DP_RD_PREV: raddr = AW'(h_reg - ONE_X);
            DP_RD_P2:   raddr = AW'(h_reg + TWO_X);
            DP_RD_END:  raddr = end_reg[AW-1:0];
            default:    ;
        endcase
    end

    always_comb
    begin
        st.init_last  = (h_reg == N_X - ONE_X);
        st.kind_alloc = (req_reg.kind == KIND_FIRST) || (req_reg.kind == KIND_BEST);
        st.kind_free  = (req_reg.kind == KIND_FREE);
        st.addr_bad   = (req_reg.block_address == '0) || (XW'(req_reg.block_address) > N_X);
        st.h_end      = (h_reg >= N_X);
        st.pick_ok    = pick_ok_reg;
        st.fit_stop   = fit_good && (req_reg.kind != KIND_BEST);
        st.co_good    = co_good;
        st.co_reach   = (acc_new >= need);
        st.split      = (remain >= TWO_X);
        st.fr_cont    = (h_reg < N_X) && (h_reg < a_x);
        st.fr_match   = (h_reg == a_x);
        st.hdr_is_pad = (r_size == TWO_X);
        st.hdr_alloc  = r_alloc;
        st.h_pos      = (h_reg != '0);
        st.p2_in      = (h_reg + TWO_X < N_X);
        st.pad_go     = before_reg || after_reg;
        st.rel_p_ok   = co_good && (r_size >= ONE_X) && (r_size <= h_reg);
        st.end_in     = (end_reg < N_X);
        st.rel_n_ok   = co_good && (r_size >= ONE_X) && (r_size <= N_X - end_reg);
        st.out_free   = !out_valid_reg || rsp_ready;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg         <= '0;
            pick_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == DP_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                DP_INIT_WR: h_reg <= h_reg + ONE_X;
                DP_LOAD, DP_FIT_RST:
                begin
                    h_reg       <= '0;
                    pick_ok_reg <= 1'b0;
                end
                DP_FIT_CHK:
                begin
                    h_reg <= h_reg + len;
                    if (fit_good && (st.fit_stop || best_better))
                    begin
                        pick_ok_reg <= 1'b1;
                    end
                end
                DP_CO_TST:
                begin
                    if (!(co_good && st.co_reach))
                    begin
                        h_reg <= h_reg + len;
                    end
                end
                DP_FR_ADV: h_reg <= h_reg + len;
                default:   ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LOAD: req_reg <= req;
            DP_FIT_CHK:
            begin
                if (fit_good && (st.fit_stop || best_better))
                begin
                    pick_reg <= h_reg;
                    plen_reg <= len;
                end
            end
            DP_CO_START:
            begin
                start_reg <= h_reg;
                acc_reg   <= '0;
            end
            DP_CO_TST:
            begin
                if (co_good)
                begin
                    acc_reg <= acc_new;
                end
                wb_h_reg <= start_reg;
                wb_s_reg <= acc_new;
                wb_a_reg <= 1'b0;
            end
            DP_PLACE1:
            begin
                wb_h_reg <= pick_reg;
                wb_s_reg <= st.split ? need : plen_reg;
                wb_a_reg <= 1'b1;
            end
            DP_PLACE2:
            begin
                wb_h_reg <= pick_reg + need;
                wb_s_reg <= remain;
                wb_a_reg <= (remain == TWO_X);
            end
            DP_FR_HDR:
            begin
                start_reg  <= h_reg;
                end_reg    <= h_reg + len;
                wb_h_reg   <= h_reg;
                wb_s_reg   <= len;
                wb_a_reg   <= 1'b0;
                before_reg <= 1'b0;
                after_reg  <= 1'b0;
            end
            DP_PAD_B: before_reg <= !r_alloc;
            DP_PAD_A: after_reg  <= !r_alloc;
            DP_REL_P:
            begin
                // merged start moves back only when the block before is taken in
                if (st.rel_p_ok)
                begin
                    start_reg <= ps_start;
                    wb_h_reg  <= ps_start;
                    wb_s_reg  <= end_reg - ps_start;
                    wb_a_reg  <= 1'b0;
                end
            end
            DP_REL_N:
            begin
                wb_h_reg <= start_reg;
                wb_s_reg <= end_reg - start_reg + r_size;
                wb_a_reg <= 1'b0;
            end
            DP_RESULT:
            begin
                rsp_reg.status        <= cmd.res;
                rsp_reg.start_address <= (cmd.res == ST_ALLOC) ? 7'(pick_reg + ONE_X) : 7'd0;
            end
            default: ;
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_RESULT) |-> (!out_valid_reg || rsp_ready))
        else $error("result written over an item not yet taken");

    a_footer_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_WR_FTR && wb_ok) |-> (ftr_x < N_X && ftr_x >= wb_h_reg))
        else $error("footer write outside its block");

endmodule

`default_nettype wire

// File: rtl/bth_ctrl.sv
// controller state machine: sequences fit search, coalescing, split and free
// depends on bth_pkg
`default_nettype none

module bth_ctrl
    import bth_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire dp_stat_t st,
    output ctl_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DISPATCH,
        S_FIT_RD, S_FIT_CK, S_FIT_AG,
        S_CO_ST, S_CO_RD, S_CO_TS,
        S_PL1, S_PL2, S_WH, S_WF,
        S_FR_RD, S_FR_ADV, S_FR_HD,
        S_PB, S_PBL, S_PA, S_PAL, S_PGO,
        S_RP, S_RPL, S_RN, S_RNL,
        S_RES
    } state_t;

    state_t     state_reg, state_next, ret_reg, ret_next;
    logic       retried_reg, retried_next;
    logic [1:0] res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            ret_reg     <= S_IDLE;
            retried_reg <= 1'b0;
            res_reg     <= ST_BADADDR;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            retried_reg <= retried_next;
            res_reg     <= res_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        retried_next = retried_reg;
        res_next     = res_reg;
        cmd.op       = DP_NOP;
        cmd.res      = res_reg;
        req_ready    = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.op = DP_INIT_WR;
                if (st.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op       = DP_LOAD;
                    retried_next = 1'b0;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (st.kind_alloc)
                begin
                    state_next = S_FIT_RD;
                end
                else if (st.kind_free && !st.addr_bad)
                begin
                    res_next   = ST_FREED;
                    state_next = S_FR_RD;
                end
                else
                begin
                    res_next   = ST_BADADDR;
                    state_next = S_RES;
                end
            end
            S_FIT_RD:
            begin
                if (st.h_end)
                begin
                    if (st.pick_ok)
                    begin
                        state_next = S_PL1;
                    end
                    else if (!retried_reg)
                    begin
                        cmd.op     = DP_FIT_RST;
                        state_next = S_CO_ST;
                    end
                    else
                    begin
                        res_next   = ST_NOSPACE;
                        state_next = S_RES;
                    end
                end
                else
                begin
                    cmd.op     = DP_RD_H;
                    state_next = S_FIT_CK;
                end
            end
            S_FIT_CK:
            begin
                cmd.op     = DP_FIT_CHK;
                state_next = st.fit_stop ? S_PL1 : S_FIT_RD;
            end
            S_FIT_AG:
            begin
                cmd.op     = DP_FIT_RST;
                state_next = S_FIT_RD;
            end
            S_CO_ST:
            begin
                if (st.h_end)
                begin
                    res_next   = ST_NOSPACE;
                    state_next = S_RES;
                end
                else
                begin
                    cmd.op     = DP_CO_START;
                    state_next = S_CO_RD;
                end
            end
            S_CO_RD:
            begin
                if (st.h_end)
                begin
                    state_next = S_CO_ST;
                end
                else
                begin
                    cmd.op     = DP_RD_H;
                    state_next = S_CO_TS;
                end
            end
            S_CO_TS:
            begin
                cmd.op = DP_CO_TST;
                if (st.co_good && st.co_reach)
                begin
                    retried_next = 1'b1;
                    ret_next     = S_FIT_AG;
                    state_next   = S_WH;
                end
                else
                begin
                    state_next = st.co_good ? S_CO_RD : S_CO_ST;
                end
            end
            S_PL1:
            begin
                cmd.op     = DP_PLACE1;
                res_next   = ST_ALLOC;
                ret_next   = st.split ? S_PL2 : S_RES;
                state_next = S_WH;
            end
            S_PL2:
            begin
                cmd.op     = DP_PLACE2;
                ret_next   = S_RES;
                state_next = S_WH;
            end
            S_WH:
            begin
                cmd.op     = DP_WR_HDR;
                state_next = S_WF;
            end
            S_WF:
            begin
                cmd.op     = DP_WR_FTR;
                state_next = ret_reg;
            end
            S_FR_RD:
            begin
                if (st.fr_cont)
                begin
                    cmd.op     = DP_RD_H;
                    state_next = S_FR_ADV;
                end
                else if (!st.fr_match)
                begin
                    res_next   = ST_BADADDR;
                    state_next = S_RES;
                end
                else
                begin
                    cmd.op     = DP_RD_H;
                    state_next = S_FR_HD;
                end
            end
            S_FR_ADV:
            begin
                cmd.op     = DP_FR_ADV;
                state_next = S_FR_RD;
            end
            S_FR_HD:
            begin
                cmd.op = DP_FR_HDR;
                if (st.hdr_is_pad)
                begin
                    state_next = S_PB;
                end
                else if (st.hdr_alloc)
                begin
                    ret_next   = S_RP;
                    state_next = S_WH;
                end
                else
                begin
                    state_next = S_RES;
                end
            end
            // padding is released only next to an unallocated neighbor
            S_PB:
            begin
                if (st.h_pos)
                begin
                    cmd.op     = DP_RD_PREV;
                    state_next = S_PBL;
                end
                else
                begin
                    state_next = S_PA;
                end
            end
            S_PBL:
            begin
                cmd.op     = DP_PAD_B;
                state_next = S_PA;
            end
            S_PA:
            begin
                if (st.p2_in)
                begin
                    cmd.op     = DP_RD_P2;
                    state_next = S_PAL;
                end
                else
                begin
                    state_next = S_PGO;
                end
            end
            S_PAL:
            begin
                cmd.op     = DP_PAD_A;
                state_next = S_PGO;
            end
            S_PGO:
            begin
                if (st.pad_go)
                begin
                    ret_next   = S_RP;
                    state_next = S_WH;
                end
                else
                begin
                    state_next = S_RES;
                end
            end
            S_RP:
            begin
                if (st.h_pos)
                begin
                    cmd.op     = DP_RD_PREV;
                    state_next = S_RPL;
                end
                else
                begin
                    state_next = S_RN;
                end
            end
            S_RPL:
            begin
                cmd.op = DP_REL_P;
                if (st.rel_p_ok)
                begin
                    ret_next   = S_RN;
                    state_next = S_WH;
                end
                else
                begin
                    state_next = S_RN;
                end
            end
            S_RN:
            begin
                if (st.end_in)
                begin
                    cmd.op     = DP_RD_END;
                    state_next = S_RNL;
                end
                else
                begin
                    state_next = S_RES;
                end
            end
            S_RNL:
            begin
                cmd.op = DP_REL_N;
                if (st.rel_n_ok)
                begin
                    ret_next   = S_RES;
                    state_next = S_WH;
                end
                else
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                if (st.out_free)
                begin
                    cmd.op     = DP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("new item taken while one is in progress");

    a_one_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_RESULT) |=> (state_reg == S_IDLE && cmd.op != DP_RESULT))
        else $error("result issued twice for one item");

endmodule

`default_nettype wire
